[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds on every rising edge outside reset.
`define NPE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the following cycle.
`define NPE_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

[hw/rtl/npe_pkg.sv]
package npe_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int MAX_WIDTH = 64;

   localparam int WIDTH_BITS = 7;
   localparam int COUNT_BITS = 7;
   localparam int INDEX_BITS = 6;
   localparam int PATTERN_BITS = 64;

   typedef logic [WIDTH_BITS-1:0]   width_type;
   typedef logic [COUNT_BITS-1:0]   count_type;
   typedef logic [INDEX_BITS-1:0]   index_type;
   typedef logic [PATTERN_BITS-1:0] pattern_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EXPAND = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_FLUSH  = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;
      logic write;
      logic scan_start;
      logic issue;
      logic emit;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic load_empty;
      logic store_empty;
      logic write_final;
      logic last_pending;
      logic issue_final;
      logic item_final;
      logic out_free;
   } status_type;

endpackage

[hw/rtl/npe_req_if.sv]
interface npe_req_if;
   import npe_pkg::*;

   logic      valid;
   logic      ready;
   width_type type_width;
   count_type copy_count;
   logic      last_type;

   modport source (output valid, output type_width, output copy_count, output last_type,
                   input ready);
   modport sink (input valid, input type_width, input copy_count, input last_type,
                 output ready);
endinterface

[hw/rtl/npe_rsp_if.sv]
interface npe_rsp_if;
   import npe_pkg::*;

   logic        valid;
   logic        ready;
   index_type   item_number;
   index_type   type_number;
   pattern_type pattern_bits;
   logic        dropped_copies;
   logic        last_result;

   modport source (output valid, output item_number, output type_number,
                   output pattern_bits, output dropped_copies, output last_result,
                   input ready);
   modport sink (input valid, input item_number, input type_number,
                 input pattern_bits, input dropped_copies, input last_result,
                 output ready);
endinterface

[hw/rtl/normal_pattern_engine_core.sv]
// Channel   Direction  Payload
// req_chan  in         type_width, copy_count, last_type
// rsp_chan  out        item_number, type_number, pattern_bits, dropped_copies, last_result
// csr       in         strip_width (write only)
//
// ST_IDLE takes a type transfer and ST_EXPAND writes each copy kept in the item store.
// On the final type each stored item passes in turn through the shift-or unit,
// which reads one stored width a cycle in ST_SCAN before ST_FLUSH and ST_EMIT.
// Reset is synchronous and returns the strip width to 64 and empties the item store.
// A stalled result holds in the output register while the next pattern is computed.
module normal_pattern_engine_core (
   input  logic                clock,
   input  logic                reset,
   npe_req_if.sink             req_chan,
   npe_rsp_if.source           rsp_chan,
   input  logic                csr_write_en,
   input  npe_pkg::width_type  csr_write_data
);
   import npe_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       ready;

   npe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_type),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   npe_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_type_width     (req_chan.type_width),
      .req_copy_count     (req_chan.copy_count),
      .req_last_type      (req_chan.last_type),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .cmd                (cmd),
      .status             (status),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_item_number    (rsp_chan.item_number),
      .rsp_type_number    (rsp_chan.type_number),
      .rsp_pattern_bits   (rsp_chan.pattern_bits),
      .rsp_dropped_copies (rsp_chan.dropped_copies),
      .rsp_last_result    (rsp_chan.last_result)
   );

   assign req_chan.ready = ready;

endmodule

[hw/rtl/npe_ctrl.sv]
`include "assert_macros.svh"

module npe_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_last,
   output logic               req_ready,
   input  npe_pkg::status_type status,
   output npe_pkg::cmd_type    cmd
);
   import npe_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (!status.load_empty) begin
                  state_in = ST_EXPAND;
               end else if (req_last) begin
                  if (status.store_empty) begin
                     cmd.clear = 1'b1;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
            end
         end
         ST_EXPAND: begin
            cmd.write = 1'b1;
            if (status.write_final) begin
               if (status.last_pending) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (status.issue_final) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.item_final) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `NPE_ASSERT(a_emit_needs_room, clock, reset, !cmd.emit || status.out_free, "emit while output register busy")
   `NPE_ASSERT_NEXT(a_flush_then_emit, clock, reset, state_ff == ST_FLUSH, state_ff == ST_EMIT, "flush not followed by emit")

endmodule

[hw/rtl/npe_datapath.sv]
`include "assert_macros.svh"

module npe_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  npe_pkg::width_type   req_type_width,
   input  npe_pkg::count_type   req_copy_count,
   input  logic                 req_last_type,
   input  logic                 csr_write_en,
   input  npe_pkg::width_type   csr_write_data,
   input  npe_pkg::cmd_type     cmd,
   output npe_pkg::status_type  status,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output npe_pkg::index_type   rsp_item_number,
   output npe_pkg::index_type   rsp_type_number,
   output npe_pkg::pattern_type rsp_pattern_bits,
   output logic                 rsp_dropped_copies,
   output logic                 rsp_last_result
);
   import npe_pkg::*;

   localparam count_type CAPACITY = count_type'(MAX_ITEMS);
   localparam width_type WIDTH_LIMIT = width_type'(MAX_WIDTH);

   width_type width_mem [MAX_ITEMS];
   index_type type_mem [MAX_ITEMS];

   width_type   strip_ff;
   count_type   item_total_ff;
   count_type   type_total_ff;
   logic        overflow_ff;
   count_type   wr_left_ff;
   width_type   wr_width_ff;
   index_type   wr_type_ff;
   logic        last_ff;
   index_type   j_ff;
   index_type   jp_ff;
   width_type   rd_width_ff;
   logic        rd_skip_ff;
   logic        rd_vld_ff;
   index_type   type_rd_ff;
   pattern_type acc_ff;
   pattern_type acc_in;
   logic        rsp_valid_ff;
   index_type   out_item_ff;
   index_type   out_type_ff;
   pattern_type out_pattern_ff;
   logic        out_dropped_ff;
   logic        out_last_ff;

   count_type   avail;
   count_type   n_store;
   width_type   eff_width;
   pattern_type mask;
   logic        item_final;

   always_comb begin
      avail     = CAPACITY - item_total_ff;
      n_store   = (req_copy_count <= avail) ? req_copy_count : avail;
      eff_width = (strip_ff >= WIDTH_LIMIT) ? WIDTH_LIMIT : strip_ff;
      if (eff_width >= width_type'(PATTERN_BITS)) begin
         mask = '1;
      end else begin
         mask = (pattern_type'(1) << eff_width[INDEX_BITS-1:0]) - pattern_type'(1);
      end
      item_final = (count_type'(j_ff) + count_type'(1)) == item_total_ff;
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.scan_start) begin
         acc_in = pattern_type'(1) & mask;
      end else if (rd_vld_ff && !rd_skip_ff && !rd_width_ff[WIDTH_BITS-1]) begin
         acc_in = (acc_ff | (acc_ff << rd_width_ff[INDEX_BITS-1:0])) & mask;
      end
   end

   always_comb begin
      status.load_empty   = (n_store == '0);
      status.store_empty  = (item_total_ff == '0);
      status.write_final  = (wr_left_ff == count_type'(1));
      status.last_pending = last_ff;
      status.issue_final  = (count_type'(jp_ff) == (item_total_ff - count_type'(1)));
      status.item_final   = item_final;
      status.out_free     = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         width_mem[item_total_ff[INDEX_BITS-1:0]] <= wr_width_ff;
         type_mem[item_total_ff[INDEX_BITS-1:0]]  <= wr_type_ff;
      end
      rd_width_ff <= width_mem[jp_ff];
      type_rd_ff  <= type_mem[j_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_ff      <= width_type'(MAX_WIDTH);
         item_total_ff <= '0;
         type_total_ff <= '0;
         overflow_ff   <= 1'b0;
         wr_left_ff    <= '0;
         last_ff       <= 1'b0;
         j_ff          <= '0;
         jp_ff         <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_en) begin
            strip_ff <= csr_write_data;
         end
         if (cmd.load) begin
            wr_width_ff <= req_type_width;
            wr_type_ff  <= type_total_ff[INDEX_BITS-1:0];
            wr_left_ff  <= n_store;
         end else if (cmd.write) begin
            wr_left_ff <= wr_left_ff - count_type'(1);
         end
         if (cmd.clear) begin
            item_total_ff <= '0;
            type_total_ff <= '0;
            overflow_ff   <= 1'b0;
            last_ff       <= 1'b0;
         end else begin
            if (cmd.load) begin
               type_total_ff <= type_total_ff + count_type'(1);
               overflow_ff   <= overflow_ff | (req_copy_count > avail);
               last_ff       <= req_last_type;
            end
            if (cmd.write) begin
               item_total_ff <= item_total_ff + count_type'(1);
            end
         end
         if (cmd.scan_start) begin
            jp_ff <= '0;
         end else if (cmd.issue) begin
            jp_ff <= jp_ff + index_type'(1);
         end
         rd_vld_ff <= cmd.issue;
         if (cmd.clear) begin
            j_ff <= '0;
         end else if (cmd.emit) begin
            j_ff <= j_ff + index_type'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_skip_ff <= (jp_ff == j_ff);
      acc_ff     <= acc_in;
      if (cmd.emit) begin
         out_item_ff    <= j_ff;
         out_type_ff    <= type_rd_ff;
         out_pattern_ff <= acc_ff;
         out_dropped_ff <= overflow_ff;
         out_last_ff    <= item_final;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_item_number    = out_item_ff;
   assign rsp_type_number    = out_type_ff;
   assign rsp_pattern_bits   = out_pattern_ff;
   assign rsp_dropped_copies = out_dropped_ff;
   assign rsp_last_result    = out_last_ff;

   `NPE_ASSERT(a_store_bound, clock, reset, item_total_ff + wr_left_ff <= CAPACITY, "overfull")
   `NPE_ASSERT(a_write_has_work, clock, reset, !cmd.write || wr_left_ff != '0, "idle write")

endmodule

[tb/tb_normal_pattern_engine_core.sv]
module tb_normal_pattern_engine_core;
   import npe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 300;

   typedef struct {
      width_type type_width;
      count_type copy_count;
      logic      last_type;
      bit        drain_first;
   } load_entry_type;

   typedef struct {
      index_type   item_number;
      index_type   type_number;
      pattern_type pattern_bits;
      logic        dropped_copies;
      logic        last_result;
   } pattern_result_type;

   logic      clock;
   logic      reset;
   logic      csr_write_en;
   width_type csr_write_data;

   npe_req_if req_chan ();
   npe_rsp_if rsp_chan ();

   normal_pattern_engine_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   load_entry_type     pending_loads[$];
   pattern_result_type expected_patterns[$];
   load_entry_type     current_load;

   width_type     stored_width[MAX_ITEMS];
   index_type     stored_type[MAX_ITEMS];
   int            stored_count;
   logic [6:0]    types_seen;
   logic          copies_lost;
   width_type     strip_limit;

   int  loads_queued;
   int  loads_accepted;
   int  patterns_checked;
   int  batches_closed;
   int  widths_used;
   int  mismatch_count;
   int  send_gap;
   int  stall_left;
   int  quiet_cycles;
   bit  idling_enabled;

   always #5 clock = ~clock;

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch in %s at pattern %0d: got %h, expected %h",
               field, patterns_checked, got, want);
      mismatch_count++;
   endtask

   function automatic pattern_type reachable_sums(input int skip);
      pattern_type mask;
      pattern_type bits;
      int          limit;
      limit = (strip_limit > MAX_WIDTH) ? MAX_WIDTH : int'(strip_limit);
      if (limit == 0) mask = '0;
      else if (limit == PATTERN_BITS) mask = '1;
      else mask = (pattern_type'(1) << limit) - pattern_type'(1);
      bits = pattern_type'(1) & mask;
      for (int k = 0; k < stored_count; k++) begin
         if (k != skip && stored_width[k] < PATTERN_BITS)
            bits = (bits | (bits << stored_width[k])) & mask;
      end
      return bits;
   endfunction

   function automatic void predict_load(input load_entry_type ld);
      pattern_result_type res;
      for (int k = 0; k < ld.copy_count; k++) begin
         if (stored_count < MAX_ITEMS) begin
            stored_width[stored_count] = ld.type_width;
            stored_type[stored_count]  = types_seen[5:0];
            stored_count++;
         end else begin
            copies_lost = 1'b1;
         end
      end
      types_seen = types_seen + 7'd1;
      if (ld.last_type) begin
         for (int j = 0; j < stored_count; j++) begin
            res.item_number    = index_type'(j);
            res.type_number    = stored_type[j];
            res.pattern_bits   = reachable_sums(j);
            res.dropped_copies = copies_lost;
            res.last_result    = (j + 1 == stored_count);
            expected_patterns.insert(expected_patterns.size(), res);
         end
         stored_count = 0;
         types_seen   = '0;
         copies_lost  = 1'b0;
         batches_closed++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_load(current_load);
            loads_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               req_chan.valid <= 1'b0;
               send_gap--;
            end else if (pending_loads.size() != 0 &&
                         !(pending_loads[0].drain_first && expected_patterns.size() != 0)) begin
               if (idling_enabled && $urandom_range(0, 5) == 0) begin
                  req_chan.valid <= 1'b0;
                  send_gap = $urandom_range(0, 13);
               end else begin
                  current_load = pending_loads.pop_front();
                  req_chan.valid      <= 1'b1;
                  req_chan.type_width <= current_load.type_width;
                  req_chan.copy_count <= current_load.copy_count;
                  req_chan.last_type  <= current_load.last_type;
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      pattern_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_patterns.size() == 0) begin
               report_mismatch("unexpected transfer", 64'(rsp_chan.item_number), '0);
            end else begin
               want = expected_patterns.pop_front();
               if (rsp_chan.item_number !== want.item_number)
                  report_mismatch("item_number", 64'(rsp_chan.item_number),
                                  64'(want.item_number));
               if (rsp_chan.type_number !== want.type_number)
                  report_mismatch("type_number", 64'(rsp_chan.type_number),
                                  64'(want.type_number));
               if (rsp_chan.pattern_bits !== want.pattern_bits)
                  report_mismatch("pattern_bits", rsp_chan.pattern_bits, want.pattern_bits);
               if (rsp_chan.dropped_copies !== want.dropped_copies)
                  report_mismatch("dropped_copies", 64'(rsp_chan.dropped_copies),
                                  64'(want.dropped_copies));
               if (rsp_chan.last_result !== want.last_result)
                  report_mismatch("last_result", 64'(rsp_chan.last_result),
                                  64'(want.last_result));
            end
            patterns_checked++;
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (idling_enabled && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left = $urandom_range(0, 13);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", quiet_cycles);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_type(input int width, input int copies, input bit last,
                             input bit drain = 1'b0);
      load_entry_type ld;
      ld.type_width  = width_type'(width);
      ld.copy_count  = count_type'(copies);
      ld.last_type   = last;
      ld.drain_first = drain;
      pending_loads.insert(pending_loads.size(), ld);
      loads_queued++;
   endtask

   task automatic queue_random_batch();
      int  types;
      int  width;
      int  copies;
      bit  drain;
      types = $urandom_range(1, 5);
      drain = ($urandom_range(0, 2) == 0);
      for (int t = 0; t < types; t++) begin
         width  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 20);
         copies = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 3);
         queue_type(width, copies, t == types - 1, drain && t == 0);
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (loads_accepted != loads_queued || expected_patterns.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_strip_width(input int value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= width_type'(value);
      @(posedge clock);
      csr_write_en   <= 1'b0;
      strip_limit = width_type'(value);
      widths_used++;
   endtask

   initial begin
      int settings[6];
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_en     = 1'b0;
      csr_write_data   = '0;
      req_chan.valid      = 1'b0;
      req_chan.type_width = '0;
      req_chan.copy_count = '0;
      req_chan.last_type  = 1'b0;
      rsp_chan.ready   = 1'b0;
      stored_count     = 0;
      types_seen       = '0;
      copies_lost      = 1'b0;
      strip_limit      = width_type'(MAX_WIDTH);
      idling_enabled   = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_strip_width(64);
      queue_type(1, 1, 0);
      queue_type(64, 1, 0);
      queue_type(0, 1, 0);
      queue_type(127, 2, 0);
      queue_type(3, 2, 1);
      queue_type(5, 0, 1);
      queue_type(10, 1, 1);
      queue_type(2, 127, 0);
      queue_type(7, 0, 0);
      queue_type(63, 3, 1);
      queue_type(1, 64, 1, 1'b1);
      wait_drained();

      write_strip_width(0);
      queue_type(4, 2, 0);
      queue_type(9, 1, 1);
      wait_drained();

      write_strip_width(127);
      queue_type(31, 2, 0);
      queue_type(32, 1, 1);
      wait_drained();

      write_strip_width(1);
      queue_type(0, 2, 0);
      queue_type(1, 2, 1);
      wait_drained();

      settings = '{64, 100, 37, 1, 8, 0};
      settings[5] = $urandom_range(2, 63);
      foreach (settings[p]) begin
         idling_enabled = ($urandom_range(0, 3) != 0);
         write_strip_width(settings[p]);
         repeat ($urandom_range(1, 3)) queue_random_batch();
         if (p == 2) begin
            // Enough types in one batch for the type number to wrap.
            for (int t = 0; t < 70; t++)
               queue_type($urandom_range(1, 12),
                          (t >= 64 || $urandom_range(0, 9) == 0) ? 1 : 0, t == 69);
         end
         wait_drained();
      end

      idling_enabled = 1'b0;
      write_strip_width(64);
      repeat (3) queue_random_batch();
      wait_drained();

      $display("covered %0d type transfers in %0d batches under %0d strip width settings",
               loads_accepted, batches_closed, widths_used);
      $display("checked %0d patterns, %0d mismatches", patterns_checked, mismatch_count);
      if (mismatch_count == 0 && expected_patterns.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
